[design/bfpr_pkg.sv]
// package for the button filter / press / repeat core
// types, widths, register defaults and register index codes; no dependencies
`timescale 1ns / 1ps

package bfpr_pkg;

	localparam int BTN_COUNT_DEF = 2;
	localparam int IN_W          = 2;
	localparam int OUT_W         = 2;
	localparam int LEVEL_W       = 4;
	localparam int LEVEL_CNT_W   = 5;
	localparam int LEVEL_MOD_MAX = 16;
	localparam int COEF_W        = 16;
	localparam int TICK_W        = 16;
	localparam int PHASE_W       = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int S_TDATA_W     = 8;
	localparam int M_TDATA_W     = 16;

	localparam logic [COEF_W-1:0]      FILTER_COEF_RST  = 16'd6554;
	localparam logic [COEF_W-1:0]      THRESHOLD_RST    = 16'd32768;
	localparam logic [TICK_W-1:0]      LONG_TICKS_RST   = 16'd200;
	localparam logic [PHASE_W-1:0]     INTERVAL_RST     = 8'd25;
	localparam logic [LEVEL_CNT_W-1:0] LEVEL_COUNT_RST  = 5'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_COEF     = 3'd0,
		CFG_PRESS_THRESHOLD = 3'd1,
		CFG_LONG_PRESS      = 3'd2,
		CFG_REPEAT_INTERVAL = 3'd3,
		CFG_LEVEL_COUNT     = 3'd4
	} cfg_idx_t;

	// settings shared by every button, interval already forced to at least one
	typedef struct packed {
		logic [COEF_W-1:0]  coef;
		logic [COEF_W-1:0]  threshold;
		logic [TICK_W-1:0]  long_ticks;
		logic [PHASE_W-1:0] interval;
	} btn_cfg_t;

	typedef struct packed {
		logic press;
		logic release_ev;
		logic repeat_ev;
		logic held;
	} btn_ev_t;

endpackage

[design/button_filter_press_repeat_core.sv]
// top level of the button filter / press / repeat core
// depends on bfpr_pkg, bfpr_button and bfpr_level
//
//   group  dir  signals                      contents
//   s_*    in   s_tvalid s_tready s_tdata    pressed_raw per tick
//   m_*    out  m_tvalid m_tready m_tdata    events, held state, level
//   cfg_*  in   cfg_we cfg_index cfg_data    register writes, no read-back
//
// one tick per cycle sustained unless the result stalls; m_tvalid rises once the tick has passed
// (input register, then result register through the per-button filter multiply)
// arst_n clears all button state, the level counter and loads register defaults
// a stalled result holds the tick in the input register; s_tready drops only
// while both the input register and the result register are full and m_tready is low
`timescale 1ns / 1ps

module button_filter_press_repeat_core import bfpr_pkg::*; #(
	parameter int BUTTON_COUNT = BTN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [1:0] pressed_raw
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] press_events, [3:2] release_events,
	                                         // [5:4] repeat_events, [7:6] held_now,
	                                         // [11:8] level_value
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [COEF_W-1:0]      coef_q;
	logic [COEF_W-1:0]      threshold_q;
	logic [TICK_W-1:0]      long_ticks_q;
	logic [PHASE_W-1:0]     interval_q;
	logic [LEVEL_CNT_W-1:0] level_count_q;

	logic                   valid_s1;
	logic [IN_W-1:0]        raw_s1;
	logic                   valid_s2;
	logic [M_TDATA_W-1:0]   data_s2;
	logic                   advance;

	btn_cfg_t               bcfg;
	btn_ev_t                ev [BUTTON_COUNT];
	logic [OUT_W-1:0]       press_v;
	logic [OUT_W-1:0]       release_v;
	logic [OUT_W-1:0]       repeat_v;
	logic [OUT_W-1:0]       held_v;
	logic [LEVEL_W-1:0]     level_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q        <= FILTER_COEF_RST;
			threshold_q   <= THRESHOLD_RST;
			long_ticks_q  <= LONG_TICKS_RST;
			interval_q    <= INTERVAL_RST;
			level_count_q <= LEVEL_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_COEF:     coef_q        <= cfg_data;
				CFG_PRESS_THRESHOLD: threshold_q   <= cfg_data;
				CFG_LONG_PRESS:      long_ticks_q  <= cfg_data;
				CFG_REPEAT_INTERVAL: interval_q    <= cfg_data[PHASE_W-1:0];
				CFG_LEVEL_COUNT:     level_count_q <= cfg_data[LEVEL_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bcfg.coef       = coef_q;
		bcfg.threshold  = threshold_q;
		bcfg.long_ticks = long_ticks_q;
		bcfg.interval   = (interval_q == '0) ? 8'd1 : interval_q;
	end

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			raw_s1 <= s_tdata[IN_W-1:0];
		end
	end

	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
		logic pin;
		if (i < IN_W) begin : g_pin
			assign pin = raw_s1[i];
		end else begin : g_nopin
			assign pin = 1'b0;
		end
		bfpr_button u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.pin    (pin),
			.cfg    (bcfg),
			.ev     (ev[i])
		);
	end

	for (genvar j = 0; j < OUT_W; j++) begin : g_out
		if (j < BUTTON_COUNT) begin : g_used
			assign press_v[j]   = ev[j].press;
			assign release_v[j] = ev[j].release_ev;
			assign repeat_v[j]  = ev[j].repeat_ev;
			assign held_v[j]    = ev[j].held;
		end else begin : g_unused
			assign press_v[j]   = 1'b0;
			assign release_v[j] = 1'b0;
			assign repeat_v[j]  = 1'b0;
			assign held_v[j]    = 1'b0;
		end
	end

	bfpr_level u_level (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.step        (ev[0].release_ev),
		.level_count (level_count_q),
		.level_next  (level_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {4'd0, level_next, held_v, repeat_v, release_v, press_v};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with an empty result register");

	a_press_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] & m_tdata[3:2]) == 2'b00))
		else $error("press and release on the same button in one transaction");

	a_repeat_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[5:4] & ~m_tdata[7:6]) == 2'b00))
		else $error("repeat on a button that is not held");

	a_press_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] & ~m_tdata[7:6]) == 2'b00))
		else $error("press on a button that is not held");
`endif

endmodule

[design/bfpr_button.sv]
// per-button low-pass filter, held flag, hold counter and repeat phase
// depends on bfpr_pkg
`timescale 1ns / 1ps

module bfpr_button import bfpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     pin,
	input  btn_cfg_t cfg,
	output btn_ev_t  ev
);

	logic [COEF_W-1:0]  filt_q;
	logic               held_q;
	logic               long_seen_q;
	logic [TICK_W-1:0]  hold_q;
	logic [PHASE_W-1:0] phase_q;

	logic [COEF_W:0]    inv_coef;
	logic [33:0]        acc;
	logic [COEF_W-1:0]  filt_d;
	logic               held_d;
	logic               long_seen_d;
	logic [TICK_W-1:0]  hold_d;
	logic [PHASE_W-1:0] phase_d;
	logic [PHASE_W-1:0] phase_base;
	logic [PHASE_W:0]   phase_inc;
	logic               fire;

	always_comb begin
		inv_coef = 17'h10000 - {1'b0, cfg.coef};
		acc = {17'd0, inv_coef} * {18'd0, filt_q} + 34'd32768
			+ (pin ? {2'd0, cfg.coef, 16'd0} : 34'd0);
		filt_d = (|acc[33:32]) ? 16'hFFFF : acc[31:16];

		held_d      = filt_d > cfg.threshold;
		long_seen_d = long_seen_q;
		ev.press      = held_d & ~held_q;
		ev.release_ev = 1'b0;
		if (!held_d && held_q) begin
			long_seen_d   = 1'b0;
			ev.release_ev = ~long_seen_q;
		end

		if (held_d) begin
			hold_d = (hold_q == 16'hFFFF) ? hold_q : hold_q + 16'd1;
		end else begin
			hold_d = '0;
		end

		phase_base = held_d ? phase_q : '0;
		if (phase_base >= cfg.interval) begin
			phase_base = '0;
		end
		phase_inc = {1'b0, phase_base} + 9'd1;
		fire      = 1'b0;
		phase_d   = held_d ? phase_q : '0;
		if (held_d && hold_d > cfg.long_ticks) begin
			fire        = phase_base == '0;
			long_seen_d = long_seen_d | fire;
			phase_d     = (phase_inc >= {1'b0, cfg.interval}) ? '0 : phase_inc[PHASE_W-1:0];
		end
		ev.repeat_ev = fire;
		ev.held      = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= '0;
			held_q      <= 1'b0;
			long_seen_q <= 1'b0;
			hold_q      <= '0;
			phase_q     <= '0;
		end else if (en) begin
			filt_q      <= filt_d;
			held_q      <= held_d;
			long_seen_q <= long_seen_d;
			hold_q      <= hold_d;
			phase_q     <= phase_d;
		end
	end

endmodule

[design/bfpr_level.sv]
// level counter stepped by short releases of button zero, wraps at a set count
// depends on bfpr_pkg
`timescale 1ns / 1ps

module bfpr_level import bfpr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   step,
	input  logic [LEVEL_CNT_W-1:0] level_count,
	output logic [LEVEL_W-1:0]     level_next
);

	logic [LEVEL_W-1:0]     idx_q;
	logic [LEVEL_CNT_W-1:0] modulus;
	logic [LEVEL_CNT_W-1:0] inc;

	always_comb begin
		modulus = level_count;
		if (level_count == '0) begin
			modulus = 5'd1;
		end else if (level_count > LEVEL_CNT_W'(LEVEL_MOD_MAX)) begin
			modulus = LEVEL_CNT_W'(LEVEL_MOD_MAX);
		end
		inc        = {1'b0, idx_q} + 5'd1;
		level_next = idx_q;
		if (step) begin
			level_next = (inc >= modulus) ? '0 : inc[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (en) begin
			idx_q <= level_next;
		end
	end

endmodule

[tb/sv/button_filter_press_repeat_core_check.sv]
// checker for button_filter_press_repeat_core: watches the tick, result and register ports,
// predicts each result and compares it field by field with what the core delivers
// depends on bfpr_pkg only
`timescale 1ns / 1ps

module button_filter_press_repeat_core_check import bfpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output int                    ticks_checked,
	output int                    press_total,
	output int                    release_total,
	output int                    repeat_total
);

	// same bit order as m_tdata[11:0]
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [OUT_W-1:0]   held;
		logic [OUT_W-1:0]   rpt;
		logic [OUT_W-1:0]   rel;
		logic [OUT_W-1:0]   prs;
	} tick_outcome_t;

	logic [COEF_W-1:0]      coef_r;
	logic [COEF_W-1:0]      thr_r;
	logic [TICK_W-1:0]      long_r;
	logic [PHASE_W-1:0]     intv_r;
	logic [LEVEL_CNT_W-1:0] lcnt_r;

	logic [COEF_W-1:0]  smoothed [BTN_COUNT_DEF];
	logic               is_held  [BTN_COUNT_DEF];
	logic               was_long [BTN_COUNT_DEF];
	logic [TICK_W-1:0]  held_for [BTN_COUNT_DEF];
	logic [PHASE_W-1:0] rpt_phase[BTN_COUNT_DEF];
	logic [LEVEL_W-1:0] level_idx;

	tick_outcome_t outcome_q[$];

	function automatic logic [COEF_W-1:0] smooth(input logic [COEF_W-1:0] old, input logic pin);
		logic [39:0] acc;
		acc = 40'(17'd65536 - {1'b0, coef_r}) * 40'(old) + 40'd32768;
		if (pin)
			acc = acc + (40'(coef_r) << 16);
		acc = acc >> 16;
		return (acc > 40'd65535) ? 16'hFFFF : acc[15:0];
	endfunction

	function automatic void step_level();
		logic [LEVEL_CNT_W-1:0] modulus;
		logic [LEVEL_CNT_W-1:0] nxt;
		modulus = lcnt_r;
		if (modulus == '0)
			modulus = LEVEL_CNT_W'(1);
		if (modulus > LEVEL_CNT_W'(LEVEL_MOD_MAX))
			modulus = LEVEL_CNT_W'(LEVEL_MOD_MAX);
		nxt = {1'b0, level_idx} + 1'b1;
		if (nxt >= modulus)
			nxt = '0;
		level_idx = nxt[LEVEL_W-1:0];
	endfunction

	function automatic tick_outcome_t next_outcome(input logic [IN_W-1:0] raw);
		tick_outcome_t r;
		logic [PHASE_W:0] ph;
		logic [PHASE_W:0] intv;
		int b;
		r = '0;
		intv = (intv_r == '0) ? 9'd1 : {1'b0, intv_r};
		for (b = 0; b < BTN_COUNT_DEF; b++) begin
			smoothed[b] = smooth(smoothed[b], raw[b]);
			if (smoothed[b] > thr_r) begin
				if (!is_held[b]) begin
					is_held[b] = 1'b1;
					r.prs[b] = 1'b1;
				end
			end else if (is_held[b]) begin
				is_held[b] = 1'b0;
				if (was_long[b]) begin
					was_long[b] = 1'b0;
				end else begin
					r.rel[b] = 1'b1;
					if (b == 0)
						step_level();
				end
			end
			if (is_held[b]) begin
				if (held_for[b] != 16'hFFFF)
					held_for[b] = held_for[b] + 1'b1;
			end else begin
				held_for[b] = '0;
				rpt_phase[b] = '0;
			end
			if (is_held[b] && held_for[b] > long_r) begin
				ph = {1'b0, rpt_phase[b]};
				if (ph >= intv)
					ph = '0;
				if (ph == '0) begin
					was_long[b] = 1'b1;
					r.rpt[b] = 1'b1;
				end
				ph = ph + 1'b1;
				if (ph >= intv)
					ph = '0;
				rpt_phase[b] = ph[PHASE_W-1:0];
			end
			r.held[b] = is_held[b];
		end
		r.level = level_idx;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_outcome_t want;
		tick_outcome_t got;
		if (!arst_n) begin
			coef_r = FILTER_COEF_RST;
			thr_r = THRESHOLD_RST;
			long_r = LONG_TICKS_RST;
			intv_r = INTERVAL_RST;
			lcnt_r = LEVEL_COUNT_RST;
			for (int b = 0; b < BTN_COUNT_DEF; b++) begin
				smoothed[b] = '0;
				is_held[b] = 1'b0;
				was_long[b] = 1'b0;
				held_for[b] = '0;
				rpt_phase[b] = '0;
			end
			level_idx = '0;
			outcome_q.delete();
			fail_count = 0;
			ticks_checked = 0;
			press_total = 0;
			release_total = 0;
			repeat_total = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FILTER_COEF:     coef_r = cfg_data[COEF_W-1:0];
					CFG_PRESS_THRESHOLD: thr_r = cfg_data[COEF_W-1:0];
					CFG_LONG_PRESS:      long_r = cfg_data[TICK_W-1:0];
					CFG_REPEAT_INTERVAL: intv_r = cfg_data[PHASE_W-1:0];
					CFG_LEVEL_COUNT:     lcnt_r = cfg_data[LEVEL_CNT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(next_outcome(s_tdata[IN_W-1:0]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(tick_outcome_t)-1:0];
				if (outcome_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"unexpected result transaction: ",
							"press %b release %b repeat %b held %b level %0d"},
							got.prs, got.rel, got.rpt, got.held, got.level);
				end else begin
					want = outcome_q.pop_front();
					ticks_checked++;
					press_total += $countones(want.prs);
					release_total += $countones(want.rel);
					repeat_total += $countones(want.rpt);
					if (got.prs !== want.prs || got.rel !== want.rel || got.rpt !== want.rpt ||
							got.held !== want.held || got.level !== want.level) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"tick %0d mismatch: expected press %b release %b ",
								"repeat %b held %b level %0d, got press %b release %b ",
								"repeat %b held %b level %0d"},
								ticks_checked, want.prs, want.rel, want.rpt, want.held,
								want.level, got.prs, got.rel, got.rpt, got.held, got.level);
					end
				end
			end
		end
		outstanding = outcome_q.size();
	end

endmodule

[tb/sv/button_filter_press_repeat_core_test.sv]
// top of the button_filter_press_repeat_core test: clock, reset, tick stimulus, register
// settings and random back-pressure; results are judged by button_filter_press_repeat_core_check
// depends on bfpr_pkg, the core and the checker
`timescale 1ns / 1ps

module button_filter_press_repeat_core_test;
	import bfpr_pkg::*;

	localparam int RANDOM_TICKS = 1200;
	localparam int PHASES       = 8;
	localparam int LONG_HOLD    = 260;
	localparam int DRAIN        = 8;
	localparam int CYCLE_LIMIT  = 60_000;

	typedef enum int {PICK_MIX, PICK_ZERO, PICK_ONES} pick_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fails, pending, ticks, presses, releases, repeats;
	int settings = 0;
	int cycles = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	logic [IN_W-1:0] want_down = '0;
	int              run_left [IN_W];

	always #1 clk = ~clk;

	button_filter_press_repeat_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	button_filter_press_repeat_core_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fails), .outstanding(pending), .ticks_checked(ticks),
		.press_total(presses), .release_total(releases), .repeat_total(repeats)
	);

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= rx_steady || ($urandom_range(0, 99) >= 38);
		else
			m_tready <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit reached, %0d results outstanding", pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// held and released runs per button, with the odd bounce on the pin
	function automatic logic [IN_W-1:0] next_raw();
		logic [IN_W-1:0] raw;
		int b;
		for (b = 0; b < IN_W; b++) begin
			if (run_left[b] == 0) begin
				want_down[b] = ~want_down[b];
				run_left[b] = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 400)
					: $urandom_range(1, 40);
			end
			run_left[b]--;
			raw[b] = want_down[b] ^ ($urandom_range(0, 99) < 4);
		end
		return raw;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_field(input int lo, input int hi,
			input int bits, input pick_mode_t mode);
		logic [CFG_DATA_W-1:0] v;
		int sel;
		sel = (mode == PICK_ZERO) ? 0 : (mode == PICK_ONES) ? 1 : $urandom_range(0, 7);
		case (sel)
			0:       v = '0;
			1:       v = CFG_DATA_W'((1 << bits) - 1);
			default: v = CFG_DATA_W'($urandom_range(lo, hi));
		endcase
		// unused upper write bits must be ignored
		if (bits < CFG_DATA_W && $urandom_range(0, 1))
			v = v | (CFG_DATA_W'($urandom) << bits);
		return v;
	endfunction

	task automatic send_tick(input logic [IN_W-1:0] raw);
		while (!tx_steady && $urandom_range(0, 99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(raw);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] coef, thr, long_ticks, intv, lcount);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FILTER_COEF;
		cfg_data <= coef;
		@(posedge clk);
		cfg_index <= CFG_PRESS_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= long_ticks;
		@(posedge clk);
		cfg_index <= CFG_REPEAT_INTERVAL;
		cfg_data <= intv;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_COUNT;
		cfg_data <= lcount;
		@(posedge clk);
		if ($urandom_range(0, 2) == 0) begin
			// write to an index with no register behind it
			cfg_index <= CFG_IDX_W'(CFG_LEVEL_COUNT) + CFG_IDX_W'($urandom_range(1, 3));
			cfg_data <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		int phase, k;
		pick_mode_t mode;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FILTER_COEF;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: both buttons latch, then a short release steps the level
		settings++;
		repeat (8) send_tick(2'b11);
		repeat (8) send_tick(2'b00);
		settle();

		// instant filter, zero threshold, long press at once, zero interval and modulus
		load_settings(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_tick(2'b01);
		send_tick(2'b01);
		send_tick(2'b01);
		send_tick(2'b00);
		send_tick(2'b10);
		send_tick(2'b10);
		send_tick(2'b00);
		send_tick(2'b11);
		send_tick(2'b00);
		settle();

		// widest interval after a short long-press limit, then a repeat on every tick
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		load_settings(16'hFFFF, 16'h8000, 16'h0002, 16'h00FF, 16'h0010);
		repeat (LONG_HOLD) send_tick(2'b11);
		repeat (4) send_tick(2'b00);
		settle();
		load_settings(16'hFFFF, 16'h8000, 16'h00F0, 16'h0001, 16'h0010);
		repeat (LONG_HOLD) send_tick(2'b01);
		repeat (4) send_tick(2'b00);
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			tx_steady = (phase == 3);
			rx_steady = (phase == 3);
			mode = (phase == 5) ? PICK_ZERO : (phase == 6) ? PICK_ONES : PICK_MIX;
			load_settings(pick_field(3000, 65535, COEF_W, mode),
				pick_field(2000, 60000, COEF_W, mode),
				pick_field(0, 40, TICK_W, mode),
				pick_field(1, 12, PHASE_W, mode),
				pick_field(1, 16, LEVEL_CNT_W, mode));
			for (k = 0; k < RANDOM_TICKS / PHASES; k++)
				send_tick(next_raw());
			settle();
		end

		$display("checked %0d ticks under %0d register settings", ticks, settings);
		$display("events seen: %0d presses, %0d short releases, %0d repeats",
			presses, releases, repeats);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
